@@ hdl/crc8sfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8sfr_pkg
// Shared constants, result type and CRC-8 (poly 0x07) byte step for the
// framed sync-packet receiver.
// ----------------------------------------------------------------------------
package crc8sfr_pkg;

  localparam int unsigned FrameBytesDef = 8;
  localparam int unsigned PosW          = 4;
  localparam int unsigned PayloadW      = 40;

  localparam logic [7:0] CrcPoly   = 8'h07;
  localparam logic [7:0] CrcMsb    = 8'h80;
  localparam logic [7:0] StartMark = 8'hAA;
  localparam logic [7:0] StopCmd   = 8'h01;
  localparam logic [PosW-1:0] PosMax = '1;

  typedef struct packed {
    logic [31:0] time_stamp;
    logic [7:0]  extra_byte;
    logic        stop_request;
  } sync_res_t;

  // One byte through the CRC, MSB first, no reflection, no final xor.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcMsb) != 8'h00) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/crc8sfr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8sfr_if
// Valid/ready channels: received bytes in, sync requests out.
// ----------------------------------------------------------------------------
interface crc8sfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface crc8sfr_sync_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_stamp;
  logic [7:0]  extra_byte;
  logic        stop_request;

  modport source (output valid, output time_stamp, output extra_byte,
                  output stop_request, input ready);
  modport sink   (input valid, input time_stamp, input extra_byte,
                  input stop_request, output ready);
endinterface

@@ hdl/crc8sfr_frame_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8sfr_frame_check
// Per-packet state: byte position, running CRC, start mark, command and
// payload. Flags a valid frame on its last byte.
// ----------------------------------------------------------------------------
module crc8sfr_frame_check
  import crc8sfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       eop_i,
  output logic       hit_o,
  output sync_res_t  res_o
);

  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);
  localparam logic [PosW-1:0] PayPos  = PosW'(2);

  logic [PosW-1:0]     pos_q, pos_d;
  logic [7:0]          crc_q, crc_d;
  logic                start_q, start_d;
  logic [7:0]          cmd_q, cmd_d;
  logic [PayloadW-1:0] pay_q, pay_d;

  logic                first;
  logic [7:0]          crc_base, cmd_base;
  logic [PayloadW-1:0] pay_base;

  always_comb begin
    first    = (pos_q == '0);
    crc_base = first ? 8'h00 : crc_q;
    cmd_base = first ? 8'h00 : cmd_q;
    pay_base = first ? '0 : pay_q;
    start_d  = first ? (data_byte_i == StartMark) : start_q;
    cmd_d    = (pos_q == PosW'(1)) ? data_byte_i : cmd_base;
    pay_d    = ((pos_q >= PayPos) && (pos_q < LastPos)) ?
               {pay_base[PayloadW-9:0], data_byte_i} : pay_base;
    crc_d    = (pos_q < LastPos) ? crc8_step(crc_base, data_byte_i) : crc_base;
    if (eop_i) begin
      pos_d = '0;
    end else begin
      pos_d = (pos_q == PosMax) ? PosMax : pos_q + PosW'(1);
    end
    hit_o              = eop_i && (pos_q == LastPos) && start_d && (data_byte_i == crc_d);
    res_o.time_stamp   = pay_d[PayloadW-1:8];
    res_o.extra_byte   = pay_d[7:0];
    res_o.stop_request = (cmd_d == StopCmd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
    end
  end

  // Cleared on the first byte of each packet, so no reset needed.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      crc_q   <= crc_d;
      start_q <= start_d;
      cmd_q   <= cmd_d;
      pay_q   <= pay_d;
    end
  end

endmodule

@@ hdl/crc8_sync_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_sync_frame_receiver_unit
// Framed sync-packet receiver: checks length, start mark and CRC-8 and
// issues one sync request per good frame.
// ----------------------------------------------------------------------------
// Path: a frame's last byte passes from the input register through the check,
// and its request is written to the result register when that byte advances.
// Throughput: one byte per cycle unless a good frame's last byte waits on an
// untaken request; set by the combinational CRC step between the registers.
// A byte that gives no request never waits on the output side.
// Reset clears position, input and result valid; the first packet starts fresh.
module crc8_sync_frame_receiver_unit
  import crc8sfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  crc8sfr_byte_if.sink  in_i,
  crc8sfr_sync_if.source out_o
);

  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_eop_q;
  logic       res_v_q, res_v_d;
  sync_res_t  res_q;
  sync_res_t  frame_res;
  logic       hit;
  logic       advance;

  crc8sfr_frame_check #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .data_byte_i(in_byte_q),
    .eop_i      (in_eop_q),
    .hit_o      (hit),
    .res_o      (frame_res)
  );

  assign advance    = in_v_q && (!hit || !res_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || advance;

  always_comb begin
    res_v_d = res_v_q;
    if (advance && hit) begin
      res_v_d = 1'b1;
    end else if (out_o.ready) begin
      res_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_v_q <= in_i.valid;
      end
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_eop_q  <= in_i.end_of_packet;
    end
    if (advance && hit) begin
      res_q <= frame_res;
    end
  end

  assign out_o.valid        = res_v_q;
  assign out_o.time_stamp   = res_q.time_stamp;
  assign out_o.extra_byte   = res_q.extra_byte;
  assign out_o.stop_request = res_q.stop_request;

endmodule

@@ hdl/crc8sfr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8sfr_checker
// Port-level checks on the receiver's byte and request channels.
// ----------------------------------------------------------------------------
module crc8sfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_time_stamp_i,
  input logic [7:0]  out_extra_byte_i,
  input logic        out_stop_request_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // Input side never blocks while the result slot is empty.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result slot");

  // A new request is only seen after a byte was taken and passed the input register.
  a_rise_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_fire, 2))
    else $error("request without a recent byte");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("request dropped while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_time_stamp_i) && $stable(out_extra_byte_i) && $stable(out_stop_request_i))
    else $error("request payload changed while stalled");

endmodule

bind crc8_sync_frame_receiver_unit crc8sfr_checker u_crc8sfr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_time_stamp_i  (out_o.time_stamp),
  .out_extra_byte_i  (out_o.extra_byte),
  .out_stop_request_i(out_o.stop_request)
);
